// ----- sv/rgbhsv_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared types, constants and divider step logic for the RGB to HSV converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbhsv_pkg;

    // hue scale in 1/64 degree
    localparam int unsigned HUE_GREEN = 7680;
    localparam int unsigned HUE_BLUE  = 15360;
    localparam int unsigned HUE_FULL  = 23040;

    // field widths
    localparam int unsigned CHAN_W = 8;
    localparam int unsigned HUE_W  = 15;
    localparam int unsigned SAT_W  = 17;
    localparam int unsigned HQ_W   = 12;   // hue quotient, at most 3840

    // divider schedule: one quotient bit per step
    localparam int unsigned SAT_STEPS       = 17;
    localparam int unsigned HUE_STEPS       = 12;
    localparam int unsigned STEPS_PER_STAGE = 6;
    localparam int unsigned DIV_STAGES      = (SAT_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    // which channel is largest
    localparam logic [1:0] SECT_RED   = 2'd0;
    localparam logic [1:0] SECT_GREEN = 2'd1;
    localparam logic [1:0] SECT_BLUE  = 2'd2;

    // partial state of both long divisions
    typedef struct packed {
        logic [CHAN_W-1:0] sat_rem;
        logic [SAT_W-1:0]  sat_bits;
        logic [SAT_W-1:0]  sat_quo;
        logic [CHAN_W-1:0] sat_den;
        logic [CHAN_W-1:0] hue_rem;
        logic [HQ_W-1:0]   hue_bits;
        logic [HQ_W-1:0]   hue_quo;
        logic [CHAN_W-1:0] hue_den;
    } div_word_t;

    // data that rides along with the division
    typedef struct packed {
        logic [1:0]        sector;
        logic              neg;
        logic              undef;
        logic [CHAN_W-1:0] value;
    } side_t;

    // one pipeline stage worth of restoring division steps
    function automatic div_word_t div_steps(div_word_t w_in, int unsigned base);
        div_word_t        w;
        logic [CHAN_W:0]  t;
        w = w_in;
        for (int unsigned j = 0; j < STEPS_PER_STAGE; j++) begin
            if (base + j < SAT_STEPS) begin
                t = {w.sat_rem, w.sat_bits[SAT_W-1]};
                w.sat_bits = {w.sat_bits[SAT_W-2:0], 1'b0};
                if (t >= {1'b0, w.sat_den}) begin
                    t = t - {1'b0, w.sat_den};
                    w.sat_quo = {w.sat_quo[SAT_W-2:0], 1'b1};
                end else begin
                    w.sat_quo = {w.sat_quo[SAT_W-2:0], 1'b0};
                end
                w.sat_rem = t[CHAN_W-1:0];
            end
            if (base + j < HUE_STEPS) begin
                t = {w.hue_rem, w.hue_bits[HQ_W-1]};
                w.hue_bits = {w.hue_bits[HQ_W-2:0], 1'b0};
                if (t >= {1'b0, w.hue_den}) begin
                    t = t - {1'b0, w.hue_den};
                    w.hue_quo = {w.hue_quo[HQ_W-2:0], 1'b1};
                end else begin
                    w.hue_quo = {w.hue_quo[HQ_W-2:0], 1'b0};
                end
                w.hue_rem = t[CHAN_W-1:0];
            end
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- sv/rgbhsv_divider.sv -----
// ----------------------------------------------------------------------------
// rgbhsv_divider
// Pipelined restoring divider for saturation and hue, a few bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsv_divider (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    input  rgbhsv_pkg::div_word_t  in_div,
    input  rgbhsv_pkg::side_t      in_side,
    output logic                   out_valid,
    output rgbhsv_pkg::div_word_t  out_div,
    output rgbhsv_pkg::side_t      out_side
);
    import rgbhsv_pkg::*;

    logic      valid_reg [DIV_STAGES];
    div_word_t div_reg   [DIV_STAGES];
    side_t     side_reg  [DIV_STAGES];
    div_word_t div_next  [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++) begin : g_stage
            // steps of this stage
            if (k == 0) begin : g_first
                assign div_next[k] = div_steps(in_div, k * STEPS_PER_STAGE);

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        valid_reg[k] <= 1'b0;
                    else
                        valid_reg[k] <= in_valid;
                end

                always_ff @(posedge clk)
                begin
                    div_reg[k]  <= div_next[k];
                    side_reg[k] <= in_side;
                end
            end else begin : g_rest
                assign div_next[k] = div_steps(div_reg[k-1], k * STEPS_PER_STAGE);

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        valid_reg[k] <= 1'b0;
                    else
                        valid_reg[k] <= valid_reg[k-1];
                end

                always_ff @(posedge clk)
                begin
                    div_reg[k]  <= div_next[k];
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_div   = div_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

// ----- sv/rgb_to_hsv_converter_top.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_top
// RGB pixel to fixed point HSV, one pixel per clock.
// ----------------------------------------------------------------------------
// Throughput: one word per clock; busy is always low.
// Each word passes two front stages, three divider stages of up to
// 6 quotient bits each (17-bit saturation quotient) and one output
// register before done pulses.
// Reset clears only the valid bits; the receiver cannot stall the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_converter_top (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [7:0]  red,
    input  wire  [7:0]  green,
    input  wire  [7:0]  blue,
    output logic        done,
    output logic [14:0] hue,
    output logic        hue_undefined,
    output logic [16:0] saturation,
    output logic [7:0]  value
);
    import rgbhsv_pkg::*;

    // stage 1: largest channel, min, channel difference
    logic              s1_valid_reg;
    logic [CHAN_W-1:0] s1_max_reg, s1_max_next;
    logic [CHAN_W-1:0] s1_min_reg, s1_min_next;
    logic [CHAN_W-1:0] s1_abs_reg, s1_abs_next;
    logic              s1_neg_reg, s1_neg_next;
    logic [1:0]        s1_sect_reg, s1_sect_next;
    logic [CHAN_W:0]   diff_s;

    // stage 2: divider operands
    logic              s2_valid_reg;
    div_word_t         s2_div_reg, s2_div_next;
    side_t             s2_side_reg, s2_side_next;
    logic [CHAN_W-1:0] delta;
    logic [HQ_W-1:0]   x15;

    // divider outputs
    logic              dv_valid;
    div_word_t         dv_div;
    side_t             dv_side;

    // output stage
    logic              done_reg;
    logic [HUE_W-1:0]  hue_reg, hue_next;
    logic              undef_reg;
    logic [SAT_W-1:0]  sat_reg, sat_next;
    logic [CHAN_W-1:0] value_reg;
    logic [HUE_W:0]    off_w;
    logic [HUE_W:0]    sum_w;

    assign busy = 1'b0;

    // pick the largest channel, red then green wins ties
    always_comb
    begin
        if (red >= green && red >= blue) begin
            s1_sect_next = SECT_RED;
            s1_max_next  = red;
            diff_s       = {1'b0, green} - {1'b0, blue};
        end else if (green >= blue) begin
            s1_sect_next = SECT_GREEN;
            s1_max_next  = green;
            diff_s       = {1'b0, blue} - {1'b0, red};
        end else begin
            s1_sect_next = SECT_BLUE;
            s1_max_next  = blue;
            diff_s       = {1'b0, red} - {1'b0, green};
        end
        if (red <= green && red <= blue)
            s1_min_next = red;
        else if (green <= blue)
            s1_min_next = green;
        else
            s1_min_next = blue;
        s1_neg_next = diff_s[CHAN_W];
        s1_abs_next = diff_s[CHAN_W] ? CHAN_W'(-diff_s) : diff_s[CHAN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s1_max_reg  <= s1_max_next;
        s1_min_reg  <= s1_min_next;
        s1_abs_reg  <= s1_abs_next;
        s1_neg_reg  <= s1_neg_next;
        s1_sect_reg <= s1_sect_next;
    end

    // delta and divider start values
    always_comb
    begin
        delta = s1_max_reg - s1_min_reg;
        x15   = {s1_abs_reg, 4'b0} - {4'b0, s1_abs_reg};

        s2_div_next.sat_rem  = {1'b0, delta[CHAN_W-1:1]};
        s2_div_next.sat_bits = {delta[0], {(SAT_W-1){1'b0}}};
        s2_div_next.sat_quo  = '0;
        s2_div_next.sat_den  = s1_max_reg;
        s2_div_next.hue_rem  = x15[HQ_W-1:4];
        s2_div_next.hue_bits = {x15[3:0], {(HQ_W-4){1'b0}}};
        s2_div_next.hue_quo  = '0;
        s2_div_next.hue_den  = delta;

        s2_side_next.sector  = s1_sect_reg;
        s2_side_next.neg     = s1_neg_reg;
        s2_side_next.undef   = (delta == '0);
        s2_side_next.value   = s1_max_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_div_reg  <= s2_div_next;
        s2_side_reg <= s2_side_next;
    end

    // saturation and hue quotients
    rgbhsv_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_div    (s2_div_reg),
        .in_side   (s2_side_reg),
        .out_valid (dv_valid),
        .out_div   (dv_div),
        .out_side  (dv_side)
    );

    // hue offset, sign and wrap
    always_comb
    begin
        case (dv_side.sector)
            SECT_RED:   off_w = '0;
            SECT_GREEN: off_w = (HUE_W+1)'(HUE_GREEN);
            SECT_BLUE:  off_w = (HUE_W+1)'(HUE_BLUE);
            default:    off_w = '0;
        endcase
        if (dv_side.neg)
            sum_w = off_w - {{(HUE_W+1-HQ_W){1'b0}}, dv_div.hue_quo};
        else
            sum_w = off_w + {{(HUE_W+1-HQ_W){1'b0}}, dv_div.hue_quo};
        if (sum_w[HUE_W])
            sum_w = sum_w + (HUE_W+1)'(HUE_FULL);
        if (dv_side.undef) begin
            hue_next = '0;
            sat_next = '0;
        end else begin
            hue_next = sum_w[HUE_W-1:0];
            sat_next = dv_div.sat_quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        hue_reg   <= hue_next;
        undef_reg <= dv_side.undef;
        sat_reg   <= sat_next;
        value_reg <= dv_side.value;
    end

    assign done          = done_reg;
    assign hue           = hue_reg;
    assign hue_undefined = undef_reg;
    assign saturation    = sat_reg;
    assign value         = value_reg;

    // every accepted word comes out after a fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##6 done)
        else $error("word lost in pipeline");

    // no result without an accepted word
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 6))
        else $error("result without accepted word");

    // undefined hue carries zero hue and saturation
    a_undef: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hue_undefined) |-> (hue == '0 && saturation == '0))
        else $error("undefined hue with nonzero fields");

    // hue stays within one turn, saturation within one
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hue < HUE_W'(HUE_FULL) && saturation <= 17'd65536))
        else $error("result out of range");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rgb_to_hsv_converter_top. Pixels go in through the
// start handshake in random bursts; every done word is compared field by
// field against an HSV prediction made when the pixel was taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import rgbhsv_pkg::*;

    // hue of one sixth of a turn, in 1/64 degree
    localparam int HUE_SIXTH   = 3840;
    localparam int RANDOM_PX   = 400;
    localparam int DRAIN_WAIT  = 12;
    localparam int CYCLE_LIMIT = 60000;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic              undef;
        logic [SAT_W-1:0]  sat;
        logic [CHAN_W-1:0] value;
    } hsv_t;

    // expected hsv words in pixel order, plus the conversion itself
    class hsv_scoreboard;
        hsv_t expected_hsv[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        function hsv_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int   ri, gi, bi, mx, mn, delta, diff, base, h;
            hsv_t o;
            ri = r;
            gi = g;
            bi = b;
            mx = ri;
            if (gi > mx) mx = gi;
            if (bi > mx) mx = bi;
            mn = ri;
            if (gi < mn) mn = gi;
            if (bi < mn) mn = bi;
            delta = mx - mn;
            o.value = mx[7:0];
            o.hue   = '0;
            o.undef = 1'b1;
            o.sat   = '0;
            // black and gray leave hue undefined
            if (delta == 0)
                return o;
            o.undef = 1'b0;
            o.sat   = SAT_W'((delta * 65536) / mx);
            // red wins ties, then green
            if (ri == mx)
            begin
                diff = gi - bi;
                base = 0;
            end
            else if (gi == mx)
            begin
                diff = bi - ri;
                base = HUE_GREEN;
            end
            else
            begin
                diff = ri - gi;
                base = HUE_BLUE;
            end
            h = (HUE_SIXTH * diff) / delta + base;
            if (h < 0)
                h = h + int'(HUE_FULL);
            o.hue = h[HUE_W-1:0];
            return o;
        endfunction

        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            expected_hsv.insert(expected_hsv.size(), convert_pixel(r, g, b));
        endfunction

        function void check_result(logic [HUE_W-1:0] h, logic u, logic [SAT_W-1:0] s,
                                   logic [CHAN_W-1:0] v);
            hsv_t e;
            if (expected_hsv.size() == 0)
            begin
                $error("unexpected word: hue %0d undef %0d sat %0d value %0d", h, u, s, v);
                errors++;
                return;
            end
            e = expected_hsv.pop_front();
            if (h !== e.hue)
            begin
                $error("hue: expected %0d, actual %0d", e.hue, h);
                errors++;
            end
            if (u !== e.undef)
            begin
                $error("hue_undefined: expected %0d, actual %0d", e.undef, u);
                errors++;
            end
            if (s !== e.sat)
            begin
                $error("saturation: expected %0d, actual %0d", e.sat, s);
                errors++;
            end
            if (v !== e.value)
            begin
                $error("value: expected %0d, actual %0d", e.value, v);
                errors++;
            end
        endfunction

        function int pending();
            return expected_hsv.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [7:0]  red = '0;
    logic [7:0]  green = '0;
    logic [7:0]  blue = '0;
    wire         busy;
    wire         done;
    wire  [14:0] hue;
    wire         hue_undefined;
    wire  [16:0] saturation;
    wire  [7:0]  value;

    int            cycles = 0;
    hsv_scoreboard sb = new();

    rgb_to_hsv_converter_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .done          (done),
        .hue           (hue),
        .hue_undefined (hue_undefined),
        .saturation    (saturation),
        .value         (value)
    );

    // clock, period 4
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        cycles <= cycles + 1;

    // every done word is taken at the edge that ends its cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(hue, hue_undefined, saturation, value);
    end

    // present one pixel and hold it until the handshake takes it
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        start <= 1'b1;
        red   <= r;
        green <= g;
        blue  <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_pixel(r, g, b);
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        red   <= 8'($urandom);
        green <= 8'($urandom);
        blue  <= 8'($urandom);
        repeat (n) @(posedge clk);
    endtask

    // random pixel weighted toward gray, ties and channel extremes
    task automatic pick_pixel(output logic [7:0] r, output logic [7:0] g,
                              output logic [7:0] b);
        int   kind;
        logic [7:0] top;
        kind = $urandom_range(0, 99);
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        if (kind < 12)
        begin
            g = r;
            b = r;
        end
        else if (kind < 27)
        begin
            // two channels share the maximum
            top = 8'($urandom_range(1, 255));
            r = top;
            g = top;
            b = 8'($urandom_range(0, top));
            case ($urandom_range(0, 2))
                0: ;
                1: begin r = b; b = top; end
                default: begin g = b; b = top; end
            endcase
        end
        else if (kind < 45)
        begin
            if ($urandom_range(0, 1)) r = ($urandom_range(0, 1)) ? 8'd255 : 8'd0;
            if ($urandom_range(0, 1)) g = ($urandom_range(0, 1)) ? 8'd255 : 8'd0;
            if ($urandom_range(0, 1)) b = ($urandom_range(0, 1)) ? 8'd255 : 8'd0;
        end
    endtask

    // timeout guard
    initial
    begin
        while (cycles < CYCLE_LIMIT)
            @(posedge clk);
        $display("FAIL rgb_to_hsv_converter_top");
        $finish;
    end

    initial
    begin
        logic [23:0] directed_px[$];
        logic [7:0]  r, g, b;
        int          sent;
        int          burst;
        int          gap;

        // black, grays, primaries, ties, wraparound and tiny deltas
        directed_px = '{
            24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101,
            24'hFF0000, 24'h00FF00, 24'h0000FF,
            24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
            24'hFF0001, 24'hC80032, 24'h64C832, 24'h0A14C8,
            24'h100000, 24'h000001, 24'h010000, 24'hFEFF00,
            24'hFEFFFF, 24'hFFFEFE, 24'h7F80FF, 24'hAA55AA,
            24'h55AA55, 24'h123456
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_px[i])
        begin
            send_pixel(directed_px[i][23:16], directed_px[i][15:8], directed_px[i][7:0]);
            if ($urandom_range(0, 3) == 0)
                idle_cycles($urandom_range(1, 3));
        end

        // random bursts with random gaps, some long bursts with no gaps
        sent = 0;
        while (sent < RANDOM_PX)
        begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 8);
            repeat (burst)
            begin
                pick_pixel(r, g, b);
                send_pixel(r, g, b);
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0)
                idle_cycles(gap);
        end
        if (start)
            start <= 1'b0;

        // drain the pipeline
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS rgb_to_hsv_converter_top");
        else
            $display("FAIL rgb_to_hsv_converter_top");
        $finish;
    end

endmodule

`default_nettype wire
